// ===== rtl/core/bsh_pkg.sv =====
package bsh_pkg;

   localparam int ELEM_W          = 16;  // element width = number of bit planes
   localparam int NUM_PLANES      = ELEM_W;
   localparam int PLANE_W         = $clog2(NUM_PLANES);
   localparam int BATCH_SIZE      = 8;   // elements packed into one output byte
   localparam int SLOT_W          = $clog2(BATCH_SIZE);
   localparam int BYTE_W          = BATCH_SIZE;
   localparam int ADDR_W          = 16;
   localparam int CFG_W           = 12;
   localparam int ELEMS_PER_GROUP = 16;
   localparam int BYTES_PER_GROUP = 32;

   // per-cycle control for the plane cells
   typedef struct packed {
      logic load;   // take a fresh element from the collect chain
      logic shift;  // step to the next bit plane
   } cell_ctrl_type;

endpackage

// ===== rtl/core/bsh_collect_cell.sv =====
// One slot of the collect chain: takes its neighbor's element on each shift.
module bsh_collect_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [bsh_pkg::ELEM_W-1:0]  elem_d,
   output logic [bsh_pkg::ELEM_W-1:0]  elem_q
);

   logic [bsh_pkg::ELEM_W-1:0] elem_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         elem_ff <= elem_d;
      end
   end

   assign elem_q = elem_ff;

endmodule

// ===== rtl/core/bsh_plane_cell.sv =====
// One element of the batch being emitted; bit 0 is the current plane's bit.
module bsh_plane_cell (
   input  logic                        clock,
   input  bsh_pkg::cell_ctrl_type      ctrl,
   input  logic [bsh_pkg::ELEM_W-1:0]  elem_d,
   output logic                        plane_bit
);

   logic [bsh_pkg::ELEM_W-1:0] elem_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         elem_ff <= elem_d;
      end else if (ctrl.shift) begin
         elem_ff <= elem_ff >> 1;
      end
   end

   assign plane_bit = elem_ff[0];

endmodule

// ===== rtl/core/bitshuffle_two_byte_elements.sv =====
// Bit-transposing shuffle for a buffer of 16-bit elements.
// req_ channel: one element per transaction, in buffer order.
// rsp_ channel: one output byte per transaction with its destination offset;
//   sixteen transactions (planes 0..15) follow every eighth element.
// csr_ port: group_count write (buffer length in 16-element groups); any
//   write restarts the buffer at element 0. 0 reads as 1, large values clamp.
// Latency: the first byte of a batch is valid the cycle after the eighth
//   element is taken. Throughput: one byte per cycle while rsp_ready is high,
//   from a single plane register bank; the first seven elements of the next
//   batch are taken while the current one drains.
// The eighth element of a batch waits until plane 15 of the previous batch
//   is taken (or is being taken in the same cycle).
// Reset: group_count = 1, element index 0, no pending result.
// Receiver stall: plane bank, plane counter and address hold; the collect
//   chain keeps filling until it needs the bank.
module bitshuffle_two_byte_elements #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsh_pkg::ELEM_W-1:0]    req_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsh_pkg::ADDR_W-1:0]    rsp_out_address,
   output logic [bsh_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_run_last,
   output logic                          rsp_buffer_done,
   input  logic                          csr_write_enable,
   input  logic [bsh_pkg::CFG_W-1:0]     csr_write_data
);

   // group limit from buffer size, never below one, never above the csr range
   localparam int LIMIT_RAW  = MAX_BUFFER_BYTES / bsh_pkg::BYTES_PER_GROUP;
   localparam int LIMIT      = (LIMIT_RAW < 1) ? 1 : LIMIT_RAW;
   localparam int CFG_MAX    = (1 << bsh_pkg::CFG_W) - 1;
   localparam int GROUPS_MAX = (LIMIT > CFG_MAX) ? CFG_MAX : LIMIT;
   localparam int TOTAL_MAX  = GROUPS_MAX * bsh_pkg::ELEMS_PER_GROUP;
   localparam int IDX_W      = $clog2(TOTAL_MAX);
   localparam int GRP_W      = $clog2(GROUPS_MAX + 1);
   localparam int CHAIN_N    = bsh_pkg::BATCH_SIZE - 1;

   // configuration
   logic [GRP_W-1:0]                 groups_ff, groups_in;
   logic [IDX_W-1:0]                 total_last_ff, total_last_in;
   logic [bsh_pkg::ADDR_W-1:0]       plane_size;

   // input side
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [bsh_pkg::SLOT_W-1:0]       slot;
   logic                             req_fire;
   logic                             batch_full;
   logic                             load_batch;
   logic                             last_elem;

   // output side
   logic                             valid_ff, valid_in;
   logic [bsh_pkg::PLANE_W-1:0]      plane_ff, plane_in;
   logic [bsh_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic                             done_ff, done_in;
   logic                             rsp_fire;
   logic                             last_plane;
   bsh_pkg::cell_ctrl_type           plane_ctrl;

   logic [bsh_pkg::ELEM_W-1:0]       chain_q [CHAIN_N];
   logic [bsh_pkg::ELEM_W-1:0]       load_d  [bsh_pkg::BATCH_SIZE];

   assign slot       = idx_ff[bsh_pkg::SLOT_W-1:0];
   assign batch_full = (slot == bsh_pkg::SLOT_W'(bsh_pkg::BATCH_SIZE - 1));
   assign last_elem  = (idx_ff == total_last_ff);
   assign last_plane = (plane_ff == bsh_pkg::PLANE_W'(bsh_pkg::NUM_PLANES - 1));
   assign rsp_fire   = valid_ff && rsp_ready;

   // the eighth element needs the plane bank free, or freeing this cycle
   assign req_ready  = !batch_full || !valid_ff || (rsp_ready && last_plane);
   assign req_fire   = req_valid && req_ready;
   assign load_batch = req_fire && batch_full;

   assign plane_size = bsh_pkg::ADDR_W'(groups_ff) << 1;

   // group count clamp on write
   always_comb begin
      groups_in     = groups_ff;
      total_last_in = total_last_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            groups_in = GRP_W'(1);
         end else if (csr_write_data > bsh_pkg::CFG_W'(GROUPS_MAX)) begin
            groups_in = GRP_W'(GROUPS_MAX);
         end else begin
            groups_in = GRP_W'(csr_write_data);
         end
         total_last_in = IDX_W'(({4'b0, groups_in} << 4) - 1'b1);
      end
   end

   // element index, wraps at end of buffer, cleared by any csr write
   always_comb begin
      idx_in = idx_ff;
      if (csr_write_enable) begin
         idx_in = '0;
      end else if (req_fire) begin
         idx_in = last_elem ? '0 : idx_ff + 1'b1;
      end
   end

   // output sequencing: one plane per rsp transaction
   always_comb begin
      valid_in = valid_ff;
      plane_in = plane_ff;
      addr_in  = addr_ff;
      done_in  = done_ff;
      if (load_batch) begin
         valid_in = 1'b1;
         plane_in = '0;
         addr_in  = bsh_pkg::ADDR_W'(idx_ff >> bsh_pkg::SLOT_W);
         done_in  = last_elem;
      end else if (rsp_fire) begin
         if (last_plane) begin
            valid_in = 1'b0;
         end else begin
            plane_in = plane_ff + 1'b1;
            addr_in  = addr_ff + plane_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         groups_ff     <= GRP_W'(1);
         total_last_ff <= IDX_W'(bsh_pkg::ELEMS_PER_GROUP - 1);
         idx_ff        <= '0;
         valid_ff      <= 1'b0;
         plane_ff      <= '0;
      end else begin
         groups_ff     <= groups_in;
         total_last_ff <= total_last_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         plane_ff      <= plane_in;
      end
      addr_ff <= addr_in;
      done_ff <= done_in;
   end

   // collect chain: newest element enters at the top, oldest sits in cell 0
   genvar k;
   generate
      for (k = 0; k < CHAIN_N; k++) begin : g_chain
         bsh_collect_cell u_cell (
            .clock    (clock),
            .shift_en (req_fire && !batch_full),
            .elem_d   ((k == CHAIN_N - 1) ? req_element : chain_q[(k + 1) % CHAIN_N]),
            .elem_q   (chain_q[k])
         );
         assign load_d[k] = chain_q[k];
      end
   endgenerate
   assign load_d[bsh_pkg::BATCH_SIZE - 1] = req_element;

   assign plane_ctrl.load  = load_batch;
   assign plane_ctrl.shift = rsp_fire;

   // plane cells: cell m supplies bit m of the output byte
   generate
      for (k = 0; k < bsh_pkg::BATCH_SIZE; k++) begin : g_plane
         bsh_plane_cell u_cell (
            .clock     (clock),
            .ctrl      (plane_ctrl),
            .elem_d    (load_d[k]),
            .plane_bit (rsp_out_byte[k])
         );
      end
   endgenerate

   assign rsp_valid       = valid_ff;
   assign rsp_out_address = addr_ff;
   assign rsp_run_last    = last_plane;
   assign rsp_buffer_done = last_plane && done_ff;

endmodule

// ===== tb/bitshuffle_two_byte_elements_tb.sv =====
`timescale 1ns / 100ps

module bitshuffle_two_byte_elements_tb;

   localparam int BUFFER_BYTES_MAX = 65536;
   localparam int GROUPS_MAX       = BUFFER_BYTES_MAX / bsh_pkg::BYTES_PER_GROUP;
   localparam int DRAIN_CYCLES     = 20;   // settle time past the last byte
   localparam int HOLD_CYCLES      = 300;  // long receiver back-pressure
   localparam int IDLE_PCT         = 34;

   // one output byte of the transposed buffer
   typedef struct packed {
      logic [bsh_pkg::ADDR_W-1:0] out_address;
      logic [bsh_pkg::BYTE_W-1:0] out_byte;
      logic                       run_last;
      logic                       buffer_done;
   } plane_byte_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [bsh_pkg::ELEM_W-1:0]    req_element = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [bsh_pkg::ADDR_W-1:0]    rsp_out_address;
   logic [bsh_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_run_last;
   logic                          rsp_buffer_done;
   logic                          csr_write_enable = 1'b0;
   logic [bsh_pkg::CFG_W-1:0]     csr_write_data = '0;

   // elements waiting to be driven, and bytes the shuffle still owes us
   logic [bsh_pkg::ELEM_W-1:0]    pending_elements[$];
   plane_byte_type                expected_bytes[$];

   // shadow of the block: length setting, collected batch, buffer position
   logic [bsh_pkg::CFG_W-1:0]     group_setting = 12'd1;
   logic [bsh_pkg::ELEM_W-1:0]    batch_words[bsh_pkg::BATCH_SIZE];
   int                            element_position = 0;

   int                            error_count = 0;
   int                            tx_idle_pct = IDLE_PCT;
   int                            rx_idle_pct = IDLE_PCT;
   int                            rx_hold_left = 0;
   bit                            req_fire = 1'b0;

   bitshuffle_two_byte_elements #(
      .MAX_BUFFER_BYTES (BUFFER_BYTES_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_address  (rsp_out_address),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_buffer_done  (rsp_buffer_done),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Take one element into the shadow batch. On the eighth element of a
   // batch, queue the sixteen plane bytes in plane order.
   task automatic shuffle_element(input logic [bsh_pkg::ELEM_W-1:0] word);
      int             groups;
      int             total;
      int             idx;
      int             slot;
      bit             last_of_buffer;
      plane_byte_type pb;
      groups = (group_setting == '0) ? 1 : int'(group_setting);  // zero reads as one
      if (groups > GROUPS_MAX)
         groups = GROUPS_MAX;                                    // saturate long buffers
      total = groups * bsh_pkg::ELEMS_PER_GROUP;
      idx = (element_position >= total) ? 0 : element_position;
      slot = idx % bsh_pkg::BATCH_SIZE;
      batch_words[slot] = word;
      last_of_buffer = (idx + 1 >= total);
      element_position = last_of_buffer ? 0 : idx + 1;
      if (slot == bsh_pkg::BATCH_SIZE - 1) begin
         for (int p = 0; p < bsh_pkg::NUM_PLANES; p++) begin
            for (int m = 0; m < bsh_pkg::BATCH_SIZE; m++)
               pb.out_byte[m] = batch_words[m][p];
            pb.out_address = bsh_pkg::ADDR_W'(p * 2 * groups + idx / bsh_pkg::BATCH_SIZE);
            pb.run_last    = (p == bsh_pkg::NUM_PLANES - 1);
            pb.buffer_done = (p == bsh_pkg::NUM_PLANES - 1) && last_of_buffer;
            expected_bytes.push_back(pb);
         end
      end
   endtask

   // Sender: new element offered at the falling edge once the previous one
   // was taken; valid stays up with a steady payload until the handshake.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_elements.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            req_valid   <= 1'b1;
            req_element <= pending_elements.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random ready, plus a long hold-off counted down here.
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Monitor: everything sampled at the rising edge. A length write clears
   // the buffer position; a partial batch is simply overwritten from slot 0.
   always @(posedge clock) begin
      plane_byte_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (csr_write_enable) begin
            group_setting    = csr_write_data;
            element_position = 0;
         end
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            shuffle_element(req_element);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte addr=%0d data=%02h",
                                         rsp_out_address, rsp_out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_address !== want.out_address)
                  report_mismatch($sformatf("out_address %0d, want %0d",
                                            rsp_out_address, want.out_address));
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h at addr %0d",
                                            rsp_out_byte, want.out_byte,
                                            want.out_address));
               if (rsp_run_last !== want.run_last)
                  report_mismatch($sformatf("run_last %0b, want %0b at addr %0d",
                                            rsp_run_last, want.run_last,
                                            want.out_address));
               if (rsp_buffer_done !== want.buffer_done)
                  report_mismatch($sformatf("buffer_done %0b, want %0b at addr %0d",
                                            rsp_buffer_done, want.buffer_done,
                                            want.out_address));
            end
         end
      end
   end

   // Block until every element is taken and every byte has come out, then
   // let a partial batch settle. Checked just past the falling edge so the
   // sender's update of valid is already visible.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (pending_elements.size() > 0 || req_valid || expected_bytes.size() > 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_group_count(input logic [bsh_pkg::CFG_W-1:0] setting);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly uniform words, now and then all-zero / all-one
   function automatic logic [bsh_pkg::ELEM_W-1:0] random_element();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return bsh_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   task automatic random_phase(input logic [bsh_pkg::CFG_W-1:0] setting, input int count,
                               input int tx_pct, input int rx_pct);
      write_group_count(setting);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < count; i++)
         pending_elements.push_back(random_element());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero length reads as one group (16 elements), so two
      // batches end the buffer and the second plane-15 byte flags done.
      write_group_count('0);
      pending_elements.push_back(16'hFFFF);
      pending_elements.push_back(16'h0000);
      pending_elements.push_back(16'h8000);
      pending_elements.push_back(16'h0001);
      pending_elements.push_back(16'h5555);
      pending_elements.push_back(16'hAAAA);
      pending_elements.push_back(16'h7FFF);
      pending_elements.push_back(16'hFFFE);
      for (int k = 0; k < bsh_pkg::BATCH_SIZE; k++)
         pending_elements.push_back(bsh_pkg::ELEM_W'(16'h0101 << k));
      // partial batch, dropped by the next length write
      for (int k = 0; k < 5; k++)
         pending_elements.push_back(16'hC3A5 ^ bsh_pkg::ELEM_W'(k));

      // All-ones setting saturates to the largest buffer.
      random_phase('1, 24, IDLE_PCT, IDLE_PCT);

      // Single group with a long receiver stall: the plane bank fills and
      // the input side must back up while the sender keeps offering.
      write_group_count(12'd1);
      rx_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 64; i++)
         pending_elements.push_back(random_element());

      random_phase(12'(GROUPS_MAX), 24, IDLE_PCT, IDLE_PCT);

      // back-to-back traffic, no idling on either side
      random_phase(12'd3, 64, 0, 0);

      // short buffers, counts not always a batch multiple
      for (int r = 0; r < 4; r++)
         random_phase(12'($urandom_range(1, 6)), 24 + $urandom_range(0, 7),
                      IDLE_PCT, IDLE_PCT);

      random_phase(12'($urandom_range(0, 4095)), 24, IDLE_PCT, IDLE_PCT);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));

      if (error_count == 0) begin
         $display("PASS bitshuffle_two_byte_elements");
      end else begin
         $display("FAIL bitshuffle_two_byte_elements");
      end
      $finish;
   end

   // watchdog, far past the slowest legal run
   initial begin
      #2000000;
      $display("FAIL bitshuffle_two_byte_elements");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bsh_pkg.sv
rtl/core/bsh_collect_cell.sv
rtl/core/bsh_plane_cell.sv
rtl/core/bitshuffle_two_byte_elements.sv
tb/bitshuffle_two_byte_elements_tb.sv
